>>> hdl/vglh_pkg.sv
// shared types and constants for the value / gradient / laplacian histogram
// no dependencies
package vglh_pkg;

  localparam int unsigned VALUE_BINS_DEF  = 32;
  localparam int unsigned GRAD_BINS_DEF   = 32;
  localparam int unsigned LAP_BINS_DEF    = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_W  = 24;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned BASE_W = 17;
  localparam int unsigned SEL_W  = 5;
  localparam int unsigned CNT_W  = 8;

  localparam logic [BASE_W-1:0] VALUE_BASE_RST = 17'd0;
  localparam logic [GAIN_W-1:0] VALUE_GAIN_RST = 24'd3968;
  localparam logic [GAIN_W-1:0] GRAD_GAIN_RST  = 24'd4582;
  localparam logic [GAIN_W-1:0] LAP_GAIN_RST   = 24'd4582;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_RCLR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_VALUE_BASE = 2'd0,
    CFG_VALUE_GAIN = 2'd1,
    CFG_GRAD_GAIN  = 2'd2,
    CFG_LAP_GAIN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_SQUARE = 3'd2,
    ST_SUM    = 3'd3,
    ST_ROOT   = 3'd4,
    ST_SCALE  = 3'd5,
    ST_BIN    = 3'd6,
    ST_RMW    = 3'd7
  } state_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [15:0]      center_sample;
    logic [15:0]      left_sample;
    logic [15:0]      right_sample;
    logic [15:0]      below_sample;
    logic [15:0]      above_sample;
    logic [15:0]      back_sample;
    logic [15:0]      front_sample;
    logic [SEL_W-1:0] sel_value_bin;
    logic [SEL_W-1:0] sel_grad_bin;
    logic [SEL_W-1:0] sel_lap_bin;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] bin_count;
    logic [SEL_W-1:0] hit_value_bin;
    logic [SEL_W-1:0] hit_grad_bin;
    logic [SEL_W-1:0] hit_lap_bin;
  } out_item_t;

endpackage

>>> hdl/value_gradient_laplacian_histogram.sv
// joint value / gradient magnitude / laplacian magnitude histogram, 8-bit bins
// depends on vglh_pkg
//
// Each transfer is handled on its own. A read or read-and-clear goes from accept
// through the bin read, then the write-back. An accumulate goes through the
// squares, the sum, the bit-serial square root (two roots side by side), the
// gain multiply, then the bin clamp with the bin read, then the write-back of
// the bin memory through its single port. The result sits in an output
// register, so the next item is taken while it waits. After reset the bin
// memory, VALUE_BINS*GRAD_BINS*LAP_BINS entries with each axis rounded up to
// a power of two (32768 at the defaults), is swept to zero, one entry a cycle;
// no item is accepted during that sweep, configuration writes are.
module value_gradient_laplacian_histogram #(
  parameter int unsigned VALUE_BINS  = vglh_pkg::VALUE_BINS_DEF,
  parameter int unsigned GRAD_BINS   = vglh_pkg::GRAD_BINS_DEF,
  parameter int unsigned LAP_BINS    = vglh_pkg::LAP_BINS_DEF,
  parameter int unsigned SAMPLE_BITS = vglh_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [vglh_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  vglh_pkg::in_item_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output vglh_pkg::out_item_t      out_data_o
);

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned DW = SW + 3;
  localparam int unsigned RW = SW + 2;
  localparam int unsigned WW = 2 * RW;
  localparam int unsigned VW = $clog2(VALUE_BINS);
  localparam int unsigned GW = $clog2(GRAD_BINS);
  localparam int unsigned LW = $clog2(LAP_BINS);
  localparam int unsigned AW = VW + GW + LW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned IW = $clog2(RW);
  localparam int unsigned GN = vglh_pkg::GAIN_W;
  localparam int unsigned BW = vglh_pkg::BASE_W;
  localparam int unsigned PW = RW + GN;
  localparam int unsigned VPW = BW + GN;

  // configuration
  logic [BW-1:0] value_base_q;
  logic [GN-1:0] value_gain_q, grad_gain_q, lap_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_base_q <= vglh_pkg::VALUE_BASE_RST;
      value_gain_q <= vglh_pkg::VALUE_GAIN_RST;
      grad_gain_q  <= vglh_pkg::GRAD_GAIN_RST;
      lap_gain_q   <= vglh_pkg::LAP_GAIN_RST;
    end else if (cfg_we_i) begin
      case (vglh_pkg::cfg_idx_e'(cfg_idx_i))
        vglh_pkg::CFG_VALUE_BASE: value_base_q <= cfg_data_i[BW-1:0];
        vglh_pkg::CFG_VALUE_GAIN: value_gain_q <= cfg_data_i[GN-1:0];
        vglh_pkg::CFG_GRAD_GAIN:  grad_gain_q  <= cfg_data_i[GN-1:0];
        vglh_pkg::CFG_LAP_GAIN:   lap_gain_q   <= cfg_data_i[GN-1:0];
        default: ;
      endcase
    end
  end

  // control
  vglh_pkg::state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [IW-1:0] iter_q;
  logic          out_valid_q;
  logic          out_free;
  logic          accept;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      vglh_pkg::ST_CLEAR:  if (&clr_q) state_d = vglh_pkg::ST_IDLE;
      vglh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.opcode == vglh_pkg::OP_ACCUM) state_d = vglh_pkg::ST_SQUARE;
          else state_d = vglh_pkg::ST_BIN;
        end
      end
      vglh_pkg::ST_SQUARE: state_d = vglh_pkg::ST_SUM;
      vglh_pkg::ST_SUM:    state_d = vglh_pkg::ST_ROOT;
      vglh_pkg::ST_ROOT:   if (iter_q == IW'(RW - 1)) state_d = vglh_pkg::ST_SCALE;
      vglh_pkg::ST_SCALE:  state_d = vglh_pkg::ST_BIN;
      vglh_pkg::ST_BIN:    state_d = vglh_pkg::ST_RMW;
      vglh_pkg::ST_RMW:    if (out_free) state_d = vglh_pkg::ST_IDLE;
      default:             state_d = vglh_pkg::ST_IDLE;
    endcase
  end

  logic rd_en, wr_en, out_load;

  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      vglh_pkg::ST_IDLE: in_ready_o = 1'b1;
      vglh_pkg::ST_BIN:  rd_en = 1'b1;
      vglh_pkg::ST_RMW:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vglh_pkg::ST_CLEAR;
      clr_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vglh_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == vglh_pkg::ST_ROOT) iter_q <= iter_q + 1'b1;
      else iter_q <= '0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // item capture
  logic [1:0]    op_q;
  logic [SW-1:0] c_q, l_q, r_q, bl_q, ab_q, bk_q, fr_q;
  logic [VW-1:0] vb_q;
  logic [GW-1:0] gb_q;
  logic [LW-1:0] lb_q;
  logic [VW-1:0] sel_vb;
  logic [GW-1:0] sel_gb;
  logic [LW-1:0] sel_lb;

  assign sel_vb = (9'(in_data_i.sel_value_bin) > 9'(VALUE_BINS - 1)) ?
                  VW'(VALUE_BINS - 1) : VW'(in_data_i.sel_value_bin);
  assign sel_gb = (9'(in_data_i.sel_grad_bin) > 9'(GRAD_BINS - 1)) ?
                  GW'(GRAD_BINS - 1) : GW'(in_data_i.sel_grad_bin);
  assign sel_lb = (9'(in_data_i.sel_lap_bin) > 9'(LAP_BINS - 1)) ?
                  LW'(LAP_BINS - 1) : LW'(in_data_i.sel_lap_bin);

  // arithmetic datapath
  logic signed [DW-1:0]   dif [6];
  logic signed [2*DW-1:0] prd [6];
  logic [WW-1:0]          sq_q [6];
  logic signed [BW+1:0]   off;
  logic [VPW-1:0]         vprod_q;
  logic                   vpos_q;
  logic [WW-1:0]          rad_q [2];
  logic [RW+1:0]          rem_q [2];
  logic [RW-1:0]          root_q [2];
  logic [RW+1:0]          rem_sh [2];
  logic [RW+1:0]          trial [2];
  logic [PW-1:0]          gprod_q, lprod_q;
  logic [VPW-GN-1:0]      vbin_raw;
  logic [RW-1:0]          gbin_raw, lbin_raw;
  logic [VW-1:0]          vb_n;
  logic [GW-1:0]          gb_n;
  logic [LW-1:0]          lb_n;

  always_comb begin
    dif[0] = $signed({3'b000, r_q}) - $signed({3'b000, l_q});
    dif[1] = $signed({3'b000, ab_q}) - $signed({3'b000, bl_q});
    dif[2] = $signed({3'b000, fr_q}) - $signed({3'b000, bk_q});
    dif[3] = $signed({3'b000, r_q}) + $signed({3'b000, l_q}) - $signed({2'b00, c_q, 1'b0});
    dif[4] = $signed({3'b000, ab_q}) + $signed({3'b000, bl_q}) - $signed({2'b00, c_q, 1'b0});
    dif[5] = $signed({3'b000, fr_q}) + $signed({3'b000, bk_q}) - $signed({2'b00, c_q, 1'b0});
    for (int k = 0; k < 6; k++) prd[k] = dif[k] * dif[k];
    off = $signed({1'b0, BW'({c_q, 1'b1})}) - $signed({1'b0, value_base_q});
    for (int k = 0; k < 2; k++) begin
      rem_sh[k] = {rem_q[k][RW-1:0], rad_q[k][WW-1:WW-2]};
      trial[k]  = {root_q[k], 2'b01};
    end
  end

  assign vbin_raw = vprod_q[VPW-1:GN];
  assign gbin_raw = gprod_q[PW-1:GN];
  assign lbin_raw = lprod_q[PW-1:GN];

  // accumulate bins are clamped here, read items keep their selection
  always_comb begin
    vb_n = vb_q;
    gb_n = gb_q;
    lb_n = lb_q;
    if (op_q == vglh_pkg::OP_ACCUM) begin
      if (!vpos_q) vb_n = '0;
      else if (vbin_raw > (VPW-GN)'(VALUE_BINS - 1)) vb_n = VW'(VALUE_BINS - 1);
      else vb_n = VW'(vbin_raw);
      gb_n = (gbin_raw > RW'(GRAD_BINS - 1)) ? GW'(GRAD_BINS - 1) : GW'(gbin_raw);
      lb_n = (lbin_raw > RW'(LAP_BINS - 1)) ? LW'(LAP_BINS - 1) : LW'(lbin_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_data_i.opcode;
      c_q  <= in_data_i.center_sample[SW-1:0];
      l_q  <= in_data_i.left_sample[SW-1:0];
      r_q  <= in_data_i.right_sample[SW-1:0];
      bl_q <= in_data_i.below_sample[SW-1:0];
      ab_q <= in_data_i.above_sample[SW-1:0];
      bk_q <= in_data_i.back_sample[SW-1:0];
      fr_q <= in_data_i.front_sample[SW-1:0];
      vb_q <= sel_vb;
      gb_q <= sel_gb;
      lb_q <= sel_lb;
    end
    if (state_q == vglh_pkg::ST_SQUARE) begin
      for (int k = 0; k < 6; k++) sq_q[k] <= prd[k][WW-1:0];
      vpos_q  <= (off > 0);
      vprod_q <= VPW'(off[BW-1:0]) * VPW'(value_gain_q);
    end
    if (state_q == vglh_pkg::ST_SUM) begin
      rad_q[0]  <= sq_q[0] + sq_q[1] + sq_q[2];
      rad_q[1]  <= sq_q[3] + sq_q[4] + sq_q[5];
      rem_q[0]  <= '0;
      rem_q[1]  <= '0;
      root_q[0] <= '0;
      root_q[1] <= '0;
    end
    if (state_q == vglh_pkg::ST_ROOT) begin
      // one result bit per cycle, restoring form
      for (int k = 0; k < 2; k++) begin
        rad_q[k] <= {rad_q[k][WW-3:0], 2'b00};
        if (rem_sh[k] >= trial[k]) begin
          rem_q[k]  <= rem_sh[k] - trial[k];
          root_q[k] <= {root_q[k][RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh[k];
          root_q[k] <= {root_q[k][RW-2:0], 1'b0};
        end
      end
    end
    if (state_q == vglh_pkg::ST_SCALE) begin
      gprod_q <= PW'(root_q[0]) * PW'(grad_gain_q);
      lprod_q <= PW'(root_q[1]) * PW'(lap_gain_q);
    end
    if (state_q == vglh_pkg::ST_BIN) begin
      vb_q <= vb_n;
      gb_q <= gb_n;
      lb_q <= lb_n;
    end
  end

  // bin memory, single port, registered read
  logic [vglh_pkg::CNT_W-1:0] mem [DEPTH];
  logic [vglh_pkg::CNT_W-1:0] rd_data_q, wr_data, res_count;
  logic [AW-1:0]              addr_q, wr_addr;
  logic                       mem_we;

  // the bin's address is latched with the read and held through write-back
  always_comb begin
    if (op_q == vglh_pkg::OP_ACCUM) begin
      wr_data   = (rd_data_q == vglh_pkg::CNT_MAX) ? rd_data_q : rd_data_q + 1'b1;
      res_count = wr_data;
      wr_en     = 1'b1;
    end else begin
      wr_data   = '0;
      res_count = rd_data_q;
      wr_en     = (op_q == vglh_pkg::OP_RCLR);
    end
    mem_we  = (state_q == vglh_pkg::ST_CLEAR) || (out_load && wr_en);
    wr_addr = (state_q == vglh_pkg::ST_CLEAR) ? clr_q : addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      addr_q    <= {lb_n, gb_n, vb_n};
      rd_data_q <= mem[{lb_n, gb_n, vb_n}];
    end
    if (mem_we) mem[wr_addr] <= (state_q == vglh_pkg::ST_CLEAR) ? '0 : wr_data;
  end

  // output register
  vglh_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.bin_count     <= res_count;
      out_q.hit_value_bin <= vglh_pkg::SEL_W'(vb_q);
      out_q.hit_grad_bin  <= vglh_pkg::SEL_W'(gb_q);
      out_q.hit_lap_bin   <= vglh_pkg::SEL_W'(lb_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vglh_pkg::ST_CLEAR) |-> !in_ready_o)
    else $error("item accepted during clearing sweep");

  a_accum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && op_q == vglh_pkg::OP_ACCUM) |-> (wr_data != '0))
    else $error("accumulate wrote a zero count");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && op_q == vglh_pkg::OP_ACCUM && rd_data_q == vglh_pkg::CNT_MAX)
    |-> (wr_data == vglh_pkg::CNT_MAX))
    else $error("saturated bin wrapped");

  a_out_from_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == vglh_pkg::ST_RMW))
    else $error("result raised outside write-back");

  a_rmw_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vglh_pkg::ST_RMW && !$past(state_q == vglh_pkg::ST_RMW))
    |-> $past(rd_en))
    else $error("write-back without a preceding bin read");

endmodule
